// File: sv/updatable_max_priority_task_queue_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the updatable max-priority task queue
// Shared concurrent assertion wrappers used by the checker.
// -----------------------------------------------------------------------------
`ifndef UPDATABLE_MAX_PRIORITY_TASK_QUEUE_MACROS_SVH
`define UPDATABLE_MAX_PRIORITY_TASK_QUEUE_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define UMPQ_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("umpq assertion failed");

// Assertion on the block clock and reset.
`define UMPQ_ASSERT(label, prop) \
    `UMPQ_ASSERT_CLK(label, aclk, aresetn, prop)

`endif

// File: sv/umpq_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Task queue package
// Command and status codes and the control word of the cell chain.
// -----------------------------------------------------------------------------
package umpq_pkg;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_EDIT    = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_EXECUTE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_CONFLICT = 2'd2,
        STATUS_MISSING  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_SHIFT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     lookup;
    } cell_ctrl_t;

endpackage

// File: sv/umpq_cell.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Task queue cell
// One slot of the sorted chain; trades its entry with its neighbors.
// -----------------------------------------------------------------------------
module umpq_cell #(
    parameter int TASK_ID_BITS  = 16,
    parameter int USER_BITS     = 16,
    parameter int PRIORITY_BITS = 30
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  umpq_pkg::cell_ctrl_t     ctrl,
    input  logic [PRIORITY_BITS-1:0] b_prio,
    input  logic [TASK_ID_BITS-1:0]  b_task,
    input  logic [USER_BITS-1:0]     b_user,
    input  logic                     prev_gt,
    input  logic                     prev_valid,
    input  logic [PRIORITY_BITS-1:0] prev_prio,
    input  logic [TASK_ID_BITS-1:0]  prev_task,
    input  logic [USER_BITS-1:0]     prev_user,
    input  logic                     next_valid,
    input  logic [PRIORITY_BITS-1:0] next_prio,
    input  logic [TASK_ID_BITS-1:0]  next_task,
    input  logic [USER_BITS-1:0]     next_user,
    output logic                     valid,
    output logic [PRIORITY_BITS-1:0] prio,
    output logic [TASK_ID_BITS-1:0]  task_id,
    output logic [USER_BITS-1:0]     user,
    output logic                     gt,
    output logic                     match
);
    import umpq_pkg::*;

    logic                     valid_reg, valid_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic [TASK_ID_BITS-1:0]  task_reg, task_next;
    logic [USER_BITS-1:0]     user_reg, user_next;
    logic                     match_reg;

    // An empty cell ranks below every key.
    assign gt = valid_reg && ({prio_reg, task_reg} > {b_prio, b_task});

    always_comb begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        task_next  = task_reg;
        user_next  = user_reg;
        case (ctrl.op)
            CELL_INSERT: begin
                if (!gt) begin
                    if (prev_gt) begin
                        valid_next = 1'b1;
                        prio_next  = b_prio;
                        task_next  = b_task;
                        user_next  = b_user;
                    end else begin
                        valid_next = prev_valid;
                        prio_next  = prev_prio;
                        task_next  = prev_task;
                        user_next  = prev_user;
                    end
                end
            end
            CELL_REMOVE, CELL_SHIFT: begin
                if (ctrl.op == CELL_SHIFT || !gt) begin
                    valid_next = next_valid;
                    prio_next  = next_prio;
                    task_next  = next_task;
                    user_next  = next_user;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        prio_reg <= prio_next;
        task_reg <= task_next;
        user_reg <= user_next;
        if (ctrl.lookup) begin
            match_reg <= valid_reg && (task_reg == b_task);
        end
    end

    assign valid   = valid_reg;
    assign prio    = prio_reg;
    assign task_id = task_reg;
    assign user    = user_reg;
    assign match   = match_reg;

endmodule

// File: sv/updatable_max_priority_task_queue.sv
`timescale 1ns / 1ps
// Results: add, remove, execute-top and a missing edit raise their result word
// from EXEC, after acceptance in IDLE; a found edit raises it from INSERT. Only
// one command is handled at a time: a lookup in IDLE, then EXEC, and INSERT
// for a found edit; a command is taken only while the result register is free.
// Reset: synchronous, active low; all cell valid bits clear, so the queue is
// empty and ready right after reset.
// -----------------------------------------------------------------------------
// Updatable max-priority task queue
// A sorted chain of cells holds the live tasks, highest priority first.
// -----------------------------------------------------------------------------
module updatable_max_priority_task_queue #(
    parameter int CAPACITY      = 64,
    parameter int TASK_ID_BITS  = 16,
    parameter int USER_BITS     = 16,
    parameter int PRIORITY_BITS = 30
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_cmd,
    input  logic [USER_BITS-1:0]     s_user_id,
    input  logic [TASK_ID_BITS-1:0]  s_task_id,
    input  logic [PRIORITY_BITS-1:0] s_priority_req,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [USER_BITS-1:0]     m_user_out,
    output logic [TASK_ID_BITS-1:0]  m_task_out,
    output logic [1:0]               m_status
);
    import umpq_pkg::*;

    // The sequencer: IDLE takes a command and lets every cell compare its id
    // against it; EXEC decides using the registered match flags and drives one
    // chain operation; INSERT is the second half of a priority edit.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_INSERT
    } state_t;

    state_t                   state_reg;
    cmd_t                     cmd_reg;
    logic [USER_BITS-1:0]     user_reg;
    logic [TASK_ID_BITS-1:0]  task_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [USER_BITS-1:0]     keep_user_reg;

    logic                     m_valid_reg;
    logic [USER_BITS-1:0]     m_user_reg;
    logic [TASK_ID_BITS-1:0]  m_task_reg;
    status_t                  m_status_reg;

    // Per-cell views of the chain.
    logic                     cell_valid [CAPACITY];
    logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];
    logic [TASK_ID_BITS-1:0]  cell_task  [CAPACITY];
    logic [USER_BITS-1:0]     cell_user  [CAPACITY];
    logic                     cell_gt    [CAPACITY];
    logic                     cell_match [CAPACITY];

    cell_ctrl_t               ctrl;
    logic [PRIORITY_BITS-1:0] b_prio;
    logic [TASK_ID_BITS-1:0]  b_task;
    logic [USER_BITS-1:0]     b_user;

    logic                     found;
    logic [PRIORITY_BITS-1:0] found_prio;
    logic [USER_BITS-1:0]     found_user;
    logic                     full;
    logic                     empty;

    logic                     res_fire;
    status_t                  res_status;
    logic [USER_BITS-1:0]     res_user;
    logic [TASK_ID_BITS-1:0]  res_task;

    // The output register is free whenever a new command could reach it, so a
    // command is taken only when no word is held or the current word leaves in the same cycle.
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);

    // Since ids are unique, at most one cell matches, and an AND-OR over the
    // cells recovers that cell's priority and user.
    always_comb begin
        found      = 1'b0;
        found_prio = '0;
        found_user = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            found      = found | cell_match[i];
            found_prio = found_prio | ({PRIORITY_BITS{cell_match[i]}} & cell_prio[i]);
            found_user = found_user | ({USER_BITS{cell_match[i]}} & cell_user[i]);
        end
    end

    // Live entries are packed toward cell 0, so the ends tell full and empty.
    assign full  = cell_valid[CAPACITY-1];
    assign empty = !cell_valid[0];

    // Key broadcast to all cells. While idle, the incoming id is compared.
    // A removal uses the key of the matched entry; an insert uses the new key.
    always_comb begin
        b_task = (state_reg == S_IDLE) ? s_task_id : task_reg;
        if (state_reg == S_EXEC && (cmd_reg == CMD_EDIT || cmd_reg == CMD_REMOVE)) begin
            b_prio = found_prio;
        end else begin
            b_prio = prio_reg;
        end
        b_user = (state_reg == S_INSERT) ? keep_user_reg : user_reg;
    end

    always_comb begin
        ctrl.lookup = s_valid && s_ready;
        ctrl.op     = CELL_HOLD;
        res_fire    = 1'b0;
        res_status  = STATUS_OK;
        res_user    = '0;
        res_task    = '0;
        case (state_reg)
            S_EXEC: begin
                case (cmd_reg)
                    CMD_ADD: begin
                        res_fire = 1'b1;
                        if (found || full) begin
                            res_status = STATUS_CONFLICT;
                        end else begin
                            ctrl.op = CELL_INSERT;
                        end
                    end
                    CMD_EDIT: begin
                        if (found) begin
                            ctrl.op = CELL_REMOVE;
                        end else begin
                            res_fire   = 1'b1;
                            res_status = STATUS_MISSING;
                        end
                    end
                    CMD_REMOVE: begin
                        res_fire = 1'b1;
                        if (found) begin
                            ctrl.op = CELL_REMOVE;
                        end else begin
                            res_status = STATUS_MISSING;
                        end
                    end
                    CMD_EXECUTE: begin
                        res_fire = 1'b1;
                        if (empty) begin
                            res_status = STATUS_EMPTY;
                        end else begin
                            ctrl.op  = CELL_SHIFT;
                            res_user = cell_user[0];
                            res_task = cell_task[0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INSERT: begin
                // The edited entry was taken out, so there is always room.
                ctrl.op  = CELL_INSERT;
                res_fire = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (res_fire) begin
                m_valid_reg <= 1'b1;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    state_reg <= (cmd_reg == CMD_EDIT && found) ? S_INSERT : S_IDLE;
                end
                S_INSERT: begin
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
        if (s_valid && s_ready) begin
            cmd_reg  <= cmd_t'(s_cmd);
            user_reg <= s_user_id;
            task_reg <= s_task_id;
            prio_reg <= s_priority_req;
        end
        if (state_reg == S_EXEC) begin
            keep_user_reg <= found_user;
        end
        if (res_fire) begin
            m_user_reg   <= res_user;
            m_task_reg   <= res_task;
            m_status_reg <= res_status;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                     p_gt;
            logic                     p_valid;
            logic [PRIORITY_BITS-1:0] p_prio;
            logic [TASK_ID_BITS-1:0]  p_task;
            logic [USER_BITS-1:0]     p_user;
            logic                     n_valid;
            logic [PRIORITY_BITS-1:0] n_prio;
            logic [TASK_ID_BITS-1:0]  n_task;
            logic [USER_BITS-1:0]     n_user;

            if (g == 0) begin : g_head
                // The head behaves as if an infinitely high key stood before it.
                assign p_gt    = 1'b1;
                assign p_valid = 1'b0;
                assign p_prio  = '0;
                assign p_task  = '0;
                assign p_user  = '0;
            end else begin : g_body
                assign p_gt    = cell_gt[g-1];
                assign p_valid = cell_valid[g-1];
                assign p_prio  = cell_prio[g-1];
                assign p_task  = cell_task[g-1];
                assign p_user  = cell_user[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                // An empty slot shifts in behind the tail.
                assign n_valid = 1'b0;
                assign n_prio  = '0;
                assign n_task  = '0;
                assign n_user  = '0;
            end else begin : g_inner
                assign n_valid = cell_valid[g+1];
                assign n_prio  = cell_prio[g+1];
                assign n_task  = cell_task[g+1];
                assign n_user  = cell_user[g+1];
            end

            umpq_cell #(
                .TASK_ID_BITS (TASK_ID_BITS),
                .USER_BITS    (USER_BITS),
                .PRIORITY_BITS(PRIORITY_BITS)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .b_prio    (b_prio),
                .b_task    (b_task),
                .b_user    (b_user),
                .prev_gt   (p_gt),
                .prev_valid(p_valid),
                .prev_prio (p_prio),
                .prev_task (p_task),
                .prev_user (p_user),
                .next_valid(n_valid),
                .next_prio (n_prio),
                .next_task (n_task),
                .next_user (n_user),
                .valid     (cell_valid[g]),
                .prio      (cell_prio[g]),
                .task_id   (cell_task[g]),
                .user      (cell_user[g]),
                .gt        (cell_gt[g]),
                .match     (cell_match[g])
            );
        end
    endgenerate

    assign m_valid    = m_valid_reg;
    assign m_user_out = m_user_reg;
    assign m_task_out = m_task_reg;
    assign m_status   = m_status_reg;

endmodule

// File: sv/umpq_checker.sv
`timescale 1ns / 1ps
`include "updatable_max_priority_task_queue_macros.svh"
// -----------------------------------------------------------------------------
// Task queue checker
// Port-level assertions on the command and result channels.
// -----------------------------------------------------------------------------
module umpq_checker #(
    parameter int TASK_ID_BITS = 16,
    parameter int USER_BITS    = 16
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [USER_BITS-1:0]    m_user_out,
    input logic [TASK_ID_BITS-1:0] m_task_out,
    input logic [1:0]              m_status
);
    import umpq_pkg::*;

    // A stalled result word stays valid.
    `UMPQ_ASSERT(a_valid_hold, m_valid && !m_ready |=> m_valid)

    // A stalled result word holds its payload.
    `UMPQ_ASSERT(a_out_hold, m_valid && !m_ready |=> $stable({m_user_out, m_task_out, m_status}))

    // A result word whose status is not OK carries no task.
    `UMPQ_ASSERT(a_zero_payload, m_valid && m_status != STATUS_OK |-> {m_user_out, m_task_out} == '0)

    // Commands are handled one at a time; s_ready drops once a command is taken.
    `UMPQ_ASSERT(a_one_at_a_time, s_valid && s_ready |=> !s_ready)

    // A command is taken only when the result register will be free.
    `UMPQ_ASSERT(a_room_for_result, s_ready |-> !m_valid || m_ready)

endmodule

bind updatable_max_priority_task_queue umpq_checker #(
    .TASK_ID_BITS(TASK_ID_BITS),
    .USER_BITS   (USER_BITS)
) u_umpq_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_user_out(m_user_out),
    .m_task_out(m_task_out),
    .m_status  (m_status)
);
